/* rtl/kscle_pkg.sv */
// shared types, key codes and translation tables of the scan code line editor
package kscle_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 128;
  localparam int unsigned TABLE_ENTRIES  = 54;
  localparam int unsigned TAB_IW         = $clog2(TABLE_ENTRIES);

  localparam logic [7:0] KEY_ENTER  = 8'h1C;
  localparam logic [7:0] KEY_CAPS   = 8'h3A;
  localparam logic [7:0] KEY_BKSP   = 8'h0E;
  localparam logic [7:0] KEY_SPACE  = 8'h39;
  localparam logic [7:0] KEY_LSHIFT = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT = 8'h36;
  localparam logic [7:0] KEY_CTRL   = 8'h1D;
  localparam logic [7:0] KEY_ALT    = 8'h38;
  localparam logic [7:0] KEY_F1     = 8'h3B;
  localparam logic [7:0] KEY_F3     = 8'h3D;
  localparam logic [7:0] KEY_L      = 8'h26;
  localparam logic [7:0] KEY_P      = 8'h19;
  localparam logic [7:0] KEY_UP     = 8'h80;

  localparam logic [7:0] CASE_GAP   = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ECHO     = 3'd1,
    EV_ERASE    = 3'd2,
    EV_NEWLINE  = 3'd3,
    EV_CLEAR    = 3'd4,
    EV_TERMINAL = 3'd5,
    EV_NORMAL   = 3'd6,
    EV_TEXT     = 3'd7
  } screen_e;

  typedef enum logic [2:0] {
    OP_EVENT   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_ERASE   = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_DELIVER = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  ch;
    screen_e     evt;
    logic [1:0]  term;
    logic [6:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic caps;
    logic shift;
    logic ctrl;
    logic alt;
    logic text;
  } flags_t;

  localparam logic [7:0] PLAIN_MAP [TABLE_ENTRIES] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
    8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
    8'h2E, 8'h2F
  };

  localparam logic [7:0] SHIFT_MAP [TABLE_ENTRIES] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
    8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
    8'h3E, 8'h3F
  };

endpackage

/* rtl/kscle_front.sv */
// front end: modifier and mode tracking, key classification into commands
module kscle_front import kscle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [7:0] scan_code_i,
  input  logic [6:0] read_index_i,
  input  logic       reader_waiting_i,
  output logic       push_valid_o,
  output cmd_t       push_cmd_o,
  input  logic       push_ready_i
);

  flags_t            flags_q, flags_d;
  logic [7:0]        key_c;
  logic [TAB_IW-1:0] tab_idx;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign tab_idx      = scan_code_i[TAB_IW-1:0];

  always_comb begin
    flags_d         = flags_q;
    key_c           = 8'h00;
    push_cmd_o.op   = OP_EVENT;
    push_cmd_o.ch   = 8'h00;
    push_cmd_o.evt  = EV_NONE;
    push_cmd_o.term = 2'd0;
    push_cmd_o.idx  = read_index_i;
    if (req_type_i) begin
      push_cmd_o.op = OP_READ;
    end else if (scan_code_i == KEY_ENTER) begin
      if (flags_q.text) begin
        push_cmd_o.op = OP_APPEND;
        push_cmd_o.ch = CHAR_NL;
      end else if (reader_waiting_i) begin
        push_cmd_o.op = OP_DELIVER;
      end else begin
        push_cmd_o.op = OP_CLEAR;
      end
    end else if (scan_code_i == KEY_CAPS) begin
      flags_d.caps = ~flags_q.caps;
    end else if (scan_code_i == KEY_BKSP) begin
      push_cmd_o.op = OP_ERASE;
    end else if (scan_code_i == KEY_SPACE) begin
      push_cmd_o.op = OP_APPEND;
      push_cmd_o.ch = CHAR_SPACE;
    end else begin
      if (scan_code_i == KEY_LSHIFT || scan_code_i == KEY_RSHIFT) flags_d.shift = 1'b1;
      if (scan_code_i == (KEY_LSHIFT | KEY_UP) || scan_code_i == (KEY_RSHIFT | KEY_UP)) begin
        flags_d.shift = 1'b0;
      end
      if (scan_code_i == KEY_CTRL) flags_d.ctrl = 1'b1;
      if (scan_code_i == (KEY_CTRL | KEY_UP)) flags_d.ctrl = 1'b0;
      if (scan_code_i == KEY_ALT) flags_d.alt = 1'b1;
      if (scan_code_i == (KEY_ALT | KEY_UP)) flags_d.alt = 1'b0;

      if (flags_d.alt && scan_code_i >= KEY_F1 && scan_code_i <= KEY_F3) begin
        push_cmd_o.evt  = EV_TERMINAL;
        push_cmd_o.term = 2'(scan_code_i - KEY_F1);
      end else if (flags_d.ctrl && scan_code_i == KEY_L) begin
        push_cmd_o.evt = EV_CLEAR;
      end else if (flags_d.ctrl && scan_code_i == KEY_P) begin
        flags_d.text   = ~flags_q.text;
        push_cmd_o.evt = flags_d.text ? EV_TEXT : EV_NORMAL;
      end else if (scan_code_i < 8'(TABLE_ENTRIES)) begin
        if (flags_d.shift) begin
          key_c = SHIFT_MAP[tab_idx];
        end else begin
          key_c = PLAIN_MAP[tab_idx];
          if (flags_q.caps && key_c >= CHAR_LO_A && key_c <= CHAR_LO_Z) begin
            key_c = key_c - CASE_GAP;
          end
        end
        if (key_c >= CHAR_SPACE && key_c <= CHAR_LAST) begin
          push_cmd_o.op = OP_APPEND;
          push_cmd_o.ch = key_c;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      flags_q <= flags_d;
    end
  end

endmodule

/* rtl/kscle_fifo.sv */
// two-entry command queue between front and back
module kscle_fifo import kscle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/kscle_back.sv */
// back end: line and delivered buffers in a two-bank memory, result register
module kscle_back import kscle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  cmd_t       pop_cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] screen_event_o,
  output logic [7:0] char_out_o,
  output logic [1:0] terminal_index_o,
  output logic       line_ready_o,
  output logic [7:0] line_length_o,
  output logic [7:0] read_data_o
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned LW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned CW = (LW > 7) ? LW : 7;
  localparam int unsigned XW = (LW > 8) ? LW : 8;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e        state_q, state_d;
  logic [7:0]    mem_q [2**(AW+1)];
  logic          bank_q, bank_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [LW-1:0] dlen_q, dlen_d;
  logic [7:0]    rd_data_q;
  logic [6:0]    rd_idx_q;
  logic          full, take;
  logic          we, re;
  logic [7:0]    wr_data;
  logic [LW-1:0] len;
  logic          load;

  logic          out_valid_q;
  logic [2:0]    evt_q, evt_d;
  logic [7:0]    ch_q, ch_d;
  logic [1:0]    term_q, term_d;
  logic          rdy_q, rdy_d;
  logic [7:0]    olen_q, olen_d;
  logic [7:0]    data_q, data_d;

  function automatic logic [7:0] sat8(input logic [LW-1:0] v);
    return (XW'(v) > XW'(255)) ? 8'hFF : 8'(v);
  endfunction

  assign full        = (fill_q == LW'(LINE_DEPTH));
  assign pop_ready_o = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign take        = pop_valid_i && pop_ready_o;

  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    fill_d  = fill_q;
    dlen_d  = dlen_q;
    we      = 1'b0;
    re      = 1'b0;
    wr_data = pop_cmd_i.ch;
    len     = '0;
    load    = 1'b0;
    evt_d   = EV_NONE;
    ch_d    = 8'h00;
    term_d  = 2'd0;
    rdy_d   = 1'b0;
    olen_d  = 8'h00;
    data_d  = 8'h00;
    case (state_q)
      ST_READ: begin
        load    = 1'b1;
        olen_d  = sat8(dlen_q);
        data_d  = (CW'(rd_idx_q) < CW'(dlen_q)) ? rd_data_q : 8'h00;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (take) begin
          load = 1'b1;
          case (pop_cmd_i.op)
            OP_READ: begin
              load    = 1'b0;
              re      = 1'b1;
              state_d = ST_READ;
            end
            OP_APPEND: begin
              if (!full) begin
                we     = 1'b1;
                fill_d = fill_q + LW'(1);
                evt_d  = EV_ECHO;
                ch_d   = pop_cmd_i.ch;
              end
            end
            OP_ERASE: begin
              if (fill_q != '0) begin
                fill_d = fill_q - LW'(1);
                evt_d  = EV_ERASE;
              end
            end
            OP_CLEAR: begin
              fill_d = '0;
              evt_d  = EV_NEWLINE;
            end
            OP_DELIVER: begin
              if (!full) begin
                we      = 1'b1;
                wr_data = CHAR_NL;
                len     = fill_q + LW'(1);
              end else begin
                len     = LW'(LINE_DEPTH);
              end
              dlen_d = len;
              bank_d = ~bank_q;
              fill_d = '0;
              evt_d  = EV_NEWLINE;
              rdy_d  = 1'b1;
              olen_d = sat8(len);
            end
            default: begin
              evt_d  = pop_cmd_i.evt;
              term_d = pop_cmd_i.term;
            end
          endcase
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[{bank_q, fill_q[AW-1:0]}] <= wr_data;
    if (re) begin
      rd_data_q <= mem_q[{~bank_q, AW'(pop_cmd_i.idx)}];
      rd_idx_q  <= pop_cmd_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      bank_q      <= 1'b0;
      fill_q      <= '0;
      dlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      fill_q  <= fill_d;
      dlen_q  <= dlen_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      evt_q  <= evt_d;
      ch_q   <= ch_d;
      term_q <= term_d;
      rdy_q  <= rdy_d;
      olen_q <= olen_d;
      data_q <= data_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign screen_event_o   = evt_q;
  assign char_out_o       = ch_q;
  assign terminal_index_o = term_q;
  assign line_ready_o     = rdy_q;
  assign line_length_o    = olen_q;
  assign read_data_o      = data_q;

endmodule

/* rtl/keyboard_scan_code_line_editor.sv */
// top level of the scan code line editor: front end, command queue, back end
// path: a key beat passes the command queue and the result register; a read beat also
// the registered memory read; throughput: one key beat per cycle if results are taken;
// a read beat holds the back end for its read; a line hand-over is one bank swap, no copy
// reset: flags, mode, fill and delivered length clear at once; buffer memory is not cleared
module keyboard_scan_code_line_editor import kscle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [7:0] scan_code_i,
  input  logic [6:0] read_index_i,
  input  logic       reader_waiting_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] screen_event_o,
  output logic [7:0] char_out_o,
  output logic [1:0] terminal_index_o,
  output logic       line_ready_o,
  output logic [7:0] line_length_o,
  output logic [7:0] read_data_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  kscle_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .scan_code_i      (scan_code_i),
    .read_index_i     (read_index_i),
    .reader_waiting_i (reader_waiting_i),
    .push_valid_o     (push_valid),
    .push_cmd_o       (push_cmd),
    .push_ready_i     (push_ready)
  );

  kscle_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  kscle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_cmd_i        (pop_cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .screen_event_o   (screen_event_o),
    .char_out_o       (char_out_o),
    .terminal_index_o (terminal_index_o),
    .line_ready_o     (line_ready_o),
    .line_length_o    (line_length_o),
    .read_data_o      (read_data_o)
  );

endmodule

/* tb/sv/keyboard_scan_code_line_editor_test.sv */
// testbench for the scan code line editor: random and directed key and read beats, checked
`timescale 1ns / 1ps

module keyboard_scan_code_line_editor_test;
  import kscle_pkg::*;

  localparam int DEPTH       = LINE_DEPTH_DEF;
  localparam int ITEMS       = 600;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 20;

  localparam logic [7:0] KEY_ESC   = 8'h01;
  localparam logic [7:0] KEY_1     = 8'h02;
  localparam logic [7:0] KEY_Q     = 8'h10;
  localparam logic [7:0] KEY_SLASH = 8'h35;

  typedef struct packed {
    logic       req;
    logic [7:0] code;
    logic [6:0] idx;
    logic       waiting;
    logic [1:0] phase;
    logic       drain;
    logic       starve;
  } key_beat_t;

  typedef struct packed {
    screen_e    evt;
    logic [7:0] ch;
    logic [1:0] term;
    logic       rdy;
    logic [7:0] len;
    logic [7:0] data;
  } line_result_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_ready_o;
  logic       req_type_i       = 1'b0;
  logic [7:0] scan_code_i      = 8'h00;
  logic [6:0] read_index_i     = 7'h00;
  logic       reader_waiting_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i      = 1'b0;
  logic [2:0] screen_event_o;
  logic [7:0] char_out_o;
  logic [1:0] terminal_index_o;
  logic       line_ready_o;
  logic [7:0] line_length_o;
  logic [7:0] read_data_o;

  keyboard_scan_code_line_editor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .scan_code_i      (scan_code_i),
    .read_index_i     (read_index_i),
    .reader_waiting_i (reader_waiting_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .screen_event_o   (screen_event_o),
    .char_out_o       (char_out_o),
    .terminal_index_o (terminal_index_o),
    .line_ready_o     (line_ready_o),
    .line_length_o    (line_length_o),
    .read_data_o      (read_data_o)
  );

  always #10 clk_i = ~clk_i;

  key_beat_t    key_beats_q[$];
  line_result_t owed_results[$];
  key_beat_t    cur;

  logic [7:0] line_buf [DEPTH] = '{default: 8'h00};
  logic [7:0] dlv_buf  [DEPTH] = '{default: 8'h00};
  int         line_cnt = 0;
  logic [7:0] dlv_len  = 8'h00;
  logic       caps_q   = 1'b0;
  logic       shift_q  = 1'b0;
  logic       ctrl_q   = 1'b0;
  logic       alt_q    = 1'b0;
  logic       text_q   = 1'b0;

  int unsigned beats_in = 0, reads_in = 0, results_out = 0, fails = 0, total_beats = 0;
  int unsigned lines_out = 0, full_lines = 0, chars_dropped = 0, term_switches = 0;
  int unsigned cycles = 0;
  int          hold_left = 0;
  logic [1:0]  phase_q = 2'd0;
  logic        starve_go = 1'b0;

  logic [1:0] gen_phase  = 2'd0;
  logic       gen_drain  = 1'b0;
  logic       gen_starve = 1'b0;

  function automatic int send_idle(input logic [1:0] p);
    case (p)
      2'd1:    return 58;
      2'd3:    return 14;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall(input logic [1:0] p);
    case (p)
      2'd2:    return 58;
      2'd3:    return 14;
      default: return 0;
    endcase
  endfunction

  function automatic bit store_char(input logic [7:0] c);
    if (line_cnt >= DEPTH) begin
      chars_dropped++;
      return 1'b0;
    end
    line_buf[line_cnt] = c;
    line_cnt++;
    return 1'b1;
  endfunction

  function automatic line_result_t editor_step(input key_beat_t b);
    line_result_t r;
    logic [7:0]   k;
    logic [7:0]   c;
    r = '0;
    k = b.code;
    if (b.req) begin
      reads_in++;
      r.len  = dlv_len;
      r.data = dlv_buf[b.idx];
    end else if (k == KEY_ENTER) begin
      if (text_q) begin
        if (store_char(CHAR_NL)) begin
          r.evt = EV_ECHO;
          r.ch  = CHAR_NL;
        end
      end else begin
        if (b.waiting) begin
          dlv_buf = line_buf;
          if (line_cnt < DEPTH) begin
            dlv_buf[line_cnt] = CHAR_NL;
            if (line_cnt + 1 < DEPTH) dlv_buf[line_cnt + 1] = 8'h00;
            dlv_len = 8'(line_cnt + 1);
          end else begin
            dlv_len = 8'(DEPTH);
            full_lines++;
          end
          lines_out++;
          r.rdy = 1'b1;
          r.len = dlv_len;
        end
        line_buf = '{default: 8'h00};
        line_cnt = 0;
        r.evt    = EV_NEWLINE;
      end
    end else if (k == KEY_CAPS) begin
      caps_q = !caps_q;
    end else if (k == KEY_BKSP) begin
      if (line_cnt > 0) begin
        line_cnt--;
        line_buf[line_cnt] = 8'h00;
        r.evt = EV_ERASE;
      end
    end else if (k == KEY_SPACE) begin
      if (store_char(CHAR_SPACE)) begin
        r.evt = EV_ECHO;
        r.ch  = CHAR_SPACE;
      end
    end else begin
      if (k == KEY_LSHIFT || k == KEY_RSHIFT) shift_q = 1'b1;
      if (k == (KEY_LSHIFT | KEY_UP) || k == (KEY_RSHIFT | KEY_UP)) shift_q = 1'b0;
      if (k == KEY_CTRL) ctrl_q = 1'b1;
      if (k == (KEY_CTRL | KEY_UP)) ctrl_q = 1'b0;
      if (k == KEY_ALT) alt_q = 1'b1;
      if (k == (KEY_ALT | KEY_UP)) alt_q = 1'b0;
      if (alt_q && k >= KEY_F1 && k <= KEY_F3) begin
        term_switches++;
        r.evt  = EV_TERMINAL;
        r.term = 2'(k - KEY_F1);
      end else if (ctrl_q && k == KEY_L) begin
        r.evt = EV_CLEAR;
      end else if (ctrl_q && k == KEY_P) begin
        text_q = !text_q;
        r.evt  = text_q ? EV_TEXT : EV_NORMAL;
      end else if (k < TABLE_ENTRIES) begin
        c = shift_q ? SHIFT_MAP[k] : PLAIN_MAP[k];
        if (!shift_q && caps_q && c >= CHAR_LO_A && c <= CHAR_LO_Z) c = c - CASE_GAP;
        if (c >= CHAR_SPACE && c <= CHAR_LAST && store_char(c)) begin
          r.evt = EV_ECHO;
          r.ch  = c;
        end
      end
    end
    return r;
  endfunction

  // driver: presents queued beats, predicts each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic go;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      starve_go  <= 1'b0;
    end else begin
      go = 1'b0;
      if (in_valid_i && in_ready_o) begin
        owed_results.push_back(editor_step(cur));
        beats_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (key_beats_q.size() != 0 && !(key_beats_q[0].drain && owed_results.size() != 0)
            && $urandom_range(0, 99) >= send_idle(key_beats_q[0].phase)) begin
          cur              = key_beats_q.pop_front();
          go               = 1'b1;
          req_type_i       <= cur.req;
          scan_code_i      <= cur.code;
          read_index_i     <= cur.idx;
          reader_waiting_i <= cur.waiting;
          phase_q          <= cur.phase;
        end
        in_valid_i <= go;
      end
      starve_go <= go && cur.starve;
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (starve_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      fails++;
      if (fails < 50) $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
    end
  endtask

  // monitor: checks each result beat against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    line_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_out++;
        if (owed_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with none expected, event %0d", $time, screen_event_o);
        end else begin
          want = owed_results.pop_front();
          check_field("screen_event", 8'(want.evt), 8'(screen_event_o));
          check_field("char_out", want.ch, char_out_o);
          check_field("terminal_index", 8'(want.term), 8'(terminal_index_o));
          check_field("line_ready", 8'(want.rdy), 8'(line_ready_o));
          check_field("line_length", want.len, line_length_o);
          check_field("read_data", want.data, read_data_o);
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall(phase_q));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats accepted", cycles, beats_in);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_beat(input logic rq, input logic [7:0] code, input logic [6:0] ix,
                          input logic w);
    key_beat_t b;
    b.req      = rq;
    b.code     = code;
    b.idx      = ix;
    b.waiting  = w;
    b.phase    = gen_phase;
    b.drain    = gen_drain;
    b.starve   = gen_starve;
    gen_drain  = 1'b0;
    gen_starve = 1'b0;
    key_beats_q.push_back(b);
  endtask

  task automatic press(input logic [7:0] code);
    add_beat(1'b0, code, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
  endtask

  task automatic enter_key(input logic w);
    add_beat(1'b0, KEY_ENTER, 7'($urandom_range(0, 127)), w);
  endtask

  task automatic read_at(input int ix);
    add_beat(1'b1, 8'($urandom_range(0, 255)), 7'(ix), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [7:0] pick_char_key(input bit printable_only);
    logic [7:0] k;
    k = 8'($urandom_range(0, TABLE_ENTRIES - 1));
    while (k == KEY_ENTER || k == KEY_CTRL || k == KEY_LSHIFT || k == KEY_RSHIFT ||
           k == KEY_BKSP || (printable_only && PLAIN_MAP[k] == 8'h00))
      k = 8'($urandom_range(0, TABLE_ENTRIES - 1));
    if (!printable_only && $urandom_range(0, 9) == 0) k = KEY_SPACE;
    return k;
  endfunction

  task automatic type_keys(input int n, input bit bulk);
    int i;
    int roll;
    bit shifted;
    shifted = 1'b0;
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (!bulk && roll < 8) begin
        press(KEY_BKSP);
      end else if (!bulk && roll < 14) begin
        if (shifted) press(($urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT) | KEY_UP);
        else press($urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT);
        shifted = !shifted;
      end else if (!bulk && roll < 17) begin
        press(KEY_CAPS);
      end else begin
        press(pick_char_key(bulk));
      end
    end
    if (shifted) press(KEY_RSHIFT | KEY_UP);
  endtask

  initial begin : stimulus
    int dir_n;
    int kind;
    int n;
    int j;
    int ph;
    bit first;

    // directed beats
    enter_key(1'b1);
    read_at(0);
    press(KEY_Q);
    press(KEY_CAPS);
    press(KEY_Q);
    press(KEY_LSHIFT);
    press(KEY_1);
    press(KEY_Q);
    press(KEY_LSHIFT | KEY_UP);
    press(KEY_CAPS);
    press(KEY_SLASH);
    press(KEY_SPACE);
    enter_key(1'b1);
    enter_key(1'b0);
    press(KEY_BKSP);
    press(KEY_CTRL);
    press(KEY_L);
    press(KEY_P);
    enter_key(1'b1);
    press(KEY_Q);
    press(KEY_P);
    press(KEY_CTRL | KEY_UP);
    press(KEY_BKSP);
    press(KEY_ALT);
    press(KEY_F1);
    press(KEY_F3);
    press(KEY_ALT | KEY_UP);
    press(KEY_F1);
    press(8'hFF);
    press(KEY_ESC);
    dir_n = key_beats_q.size();

    // random sessions
    first = 1'b1;
    while (key_beats_q.size() < ITEMS) begin
      ph = (key_beats_q.size() - dir_n) * 4 / (ITEMS - dir_n);
      if (ph > 3) ph = 3;
      if (2'(ph) != gen_phase || first) gen_drain = 1'b1;
      gen_phase = 2'(ph);
      kind = $urandom_range(0, 99);
      if (first) begin
        gen_starve = 1'b1;
        type_keys(130, 1'b1);
        enter_key(1'b1);
        read_at(127);
        first = 1'b0;
      end else if (kind < 60) begin
        n = ($urandom_range(0, 99) < 5) ? $urandom_range(124, 132) : $urandom_range(0, 12);
        type_keys(n, n > 100);
        enter_key($urandom_range(0, 3) != 0);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 1)) read_at($urandom_range(0, 127));
          else read_at((n + 1 > 127) ? 127 : $urandom_range(0, n + 1));
        end
      end else if (kind < 72) begin
        press(KEY_CTRL);
        repeat ($urandom_range(1, 3)) press($urandom_range(0, 1) ? KEY_L : pick_char_key(0));
        press(KEY_CTRL | KEY_UP);
      end else if (kind < 80) begin
        press(KEY_CTRL);
        press(KEY_P);
        press(KEY_CTRL | KEY_UP);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(124, 132) : $urandom_range(0, 8);
        type_keys(n, n > 100);
        enter_key(1'($urandom_range(0, 1)));
        type_keys($urandom_range(0, 4), 1'b0);
        press(KEY_CTRL);
        press(KEY_P);
        press(KEY_CTRL | KEY_UP);
      end else if (kind < 86) begin
        press(KEY_ALT);
        repeat ($urandom_range(1, 3))
          press($urandom_range(0, 3) != 0 ? 8'(KEY_F1 + $urandom_range(0, 2)) : pick_char_key(0));
        press(KEY_ALT | KEY_UP);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 99) < 40) begin
            read_at($urandom_range(0, 127));
          end else begin
            n = $urandom_range(0, 255);
            if (8'(n) == KEY_CTRL || 8'(n) == KEY_ALT || 8'(n) == KEY_LSHIFT ||
                8'(n) == KEY_RSHIFT)
              n = n | KEY_UP;
            press(8'(n));
          end
        end
      end
    end
    total_beats = key_beats_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_in != total_beats) @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d beats (%0d reads) and %0d result beats; %0d lines handed over, %0d full",
             beats_in, reads_in, results_out, lines_out, full_lines);
    $display("%0d bytes dropped on a full line, %0d terminal switches, %0d cycles in all",
             chars_dropped, term_switches, cycles);
    if (fails == 0 && owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kscle_pkg.sv
rtl/kscle_front.sv
rtl/kscle_fifo.sv
rtl/kscle_back.sv
rtl/keyboard_scan_code_line_editor.sv
tb/sv/keyboard_scan_code_line_editor_test.sv
